### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HSL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HSL_ASSERT(lbl, clk, rst_n, prop, msg)

`define HSL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB package
// Number formats, derived widths and shared types of the converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    localparam int HUE_FRAC_BITS = 4;
    localparam int SL_FRAC_BITS  = 12;

    localparam int HUE_W = 16;
    localparam int SL_W  = 13;
    localparam int CH_W  = 8;

    localparam int SL_ONE     = 1 << SL_FRAC_BITS;
    localparam int SEC_DEG    = 60;
    localparam int TURN_DEG   = 360;
    localparam int SECTORS    = TURN_DEG / SEC_DEG;
    localparam int HUE_SECTOR = SEC_DEG << HUE_FRAC_BITS;
    localparam int HUE_TURN   = TURN_DEG << HUE_FRAC_BITS;
    localparam int SEC_W      = HUE_FRAC_BITS + 6;

    // offset that makes any signed hue non-negative, a whole number of turns
    localparam int WRAP_OFS = HUE_TURN * (((1 << (HUE_W - 1)) + HUE_TURN - 1) / HUE_TURN);
    localparam int V_W      = 18;

    // reciprocal of the sector width; estimate is q or q-1
    localparam int RCP_SH  = 24;
    localparam int RCP_MUL = (1 << RCP_SH) / HUE_SECTOR;
    localparam int RCP_W   = RCP_SH - SEC_W + 1;
    localparam int Q_W     = V_W - SEC_W + 1;

    // q / 6 as (q * 683) >> 12, exact for q below 2046
    localparam int D6_MUL = 683;
    localparam int D6_SH  = 12;

    localparam int CQ_W = 2 * SL_FRAC_BITS + 1;
    localparam int MB_W = 2 * SL_FRAC_BITS + 2;
    localparam int N_W  = MB_W + SEC_W;

    // 255 / (2 * ONE^2 * 15 * 2^(2+HFB)) = 17 / 2^CH_SH
    localparam int CH_SCALE = 255 / (SEC_DEG / 4);
    localparam int CS_W     = 5;
    localparam int CH_SH    = 2 * SL_FRAC_BITS + HUE_FRAC_BITS + 3;

    typedef enum logic [2:0] {
        SECTOR_R_Y = 3'd0,
        SECTOR_Y_G = 3'd1,
        SECTOR_G_C = 3'd2,
        SECTOR_C_B = 3'd3,
        SECTOR_B_M = 3'd4,
        SECTOR_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t          sector;
        logic [SEC_W-1:0] t;
    } hue_res_t;

endpackage

### rtl/hsl2rgb_hue.sv
// ----------------------------------------------------------------------------
// HSL to RGB hue path
// Four-stage hue wrap: sector index and distance term within the sector.
// ----------------------------------------------------------------------------
module hsl2rgb_hue (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [hsl2rgb_pkg::HUE_W-1:0]  hue,
    output hsl2rgb_pkg::hue_res_t                 res
);
    import hsl2rgb_pkg::*;

    localparam int P_W = V_W + RCP_W;
    localparam int M6_W = Q_W + D6_SH;

    logic [V_W-1:0]   v_next;
    logic [P_W-1:0]   prod_next;
    logic [V_W-1:0]   v1_reg;
    logic [P_W-1:0]   prod1_reg;

    logic [Q_W-1:0]   q_est;
    logic [V_W-1:0]   rem_full;
    logic [Q_W-1:0]   q2_reg;
    logic [SEC_W:0]   rem2_reg;

    logic [Q_W-1:0]   q3_next;
    logic [SEC_W-1:0] rem3_next;
    logic [Q_W-1:0]   q3_reg;
    logic [SEC_W-1:0] rem3_reg;

    logic [M6_W-1:0]  m6;
    logic [Q_W-1:0]   q6;
    logic [Q_W-1:0]   sec_full;
    hue_res_t         res_next;
    hue_res_t         res_reg;

    // stage 1: make non-negative, multiply by reciprocal
    assign v_next    = {{(V_W-HUE_W){hue[HUE_W-1]}}, hue} + V_W'(WRAP_OFS);
    assign prod_next = P_W'(v_next) * P_W'(RCP_MUL);

    // stage 2: quotient estimate and raw remainder
    assign q_est    = Q_W'(prod1_reg >> RCP_SH);
    assign rem_full = v1_reg - V_W'(V_W'(q_est) * V_W'(HUE_SECTOR));

    // stage 3: one correction step
    always_comb
    begin
        if (rem2_reg >= (SEC_W+1)'(HUE_SECTOR))
        begin
            q3_next   = q2_reg + Q_W'(1);
            rem3_next = SEC_W'(rem2_reg - (SEC_W+1)'(HUE_SECTOR));
        end
        else
        begin
            q3_next   = q2_reg;
            rem3_next = rem2_reg[SEC_W-1:0];
        end
    end

    // stage 4: sector = q mod 6, mirrored distance in odd sectors
    assign m6       = M6_W'(q3_reg) * M6_W'(D6_MUL);
    assign q6       = Q_W'(m6 >> D6_SH);
    assign sec_full = q3_reg - Q_W'(q6 * Q_W'(SECTORS));

    always_comb
    begin
        res_next.sector = sector_t'(sec_full[2:0]);
        if (sec_full[0])
            res_next.t = SEC_W'(HUE_SECTOR) - rem3_reg;
        else
            res_next.t = rem3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg    <= v_next;
            prod1_reg <= prod_next;
            q2_reg    <= q_est;
            rem2_reg  <= rem_full[SEC_W:0];
            q3_reg    <= q3_next;
            rem3_reg  <= rem3_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// One HSL color per item in, one 8-bit RGB color per item out.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock sustained unless the output stalls. A
// result passes through seven pipeline registers, the output register last,
// set by the hue wrap (reciprocal multiply, correction, sector split)
// followed by the secondary multiply, channel sums and final x17 scaling. An
// input skid register catches an item taken in the cycle the output stalls;
// it drains first when the stall lifts, with the input stalled meanwhile.
`include "assert_macros.svh"

module hsl_to_rgb_converter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  hsl_valid,
    output logic                                  hsl_stall,
    input  logic signed [hsl2rgb_pkg::HUE_W-1:0]  hue,
    input  logic        [hsl2rgb_pkg::SL_W-1:0]   saturation,
    input  logic        [hsl2rgb_pkg::SL_W-1:0]   lightness,
    output logic                                  rgb_valid,
    input  logic                                  rgb_stall,
    output logic        [hsl2rgb_pkg::CH_W-1:0]   red,
    output logic        [hsl2rgb_pkg::CH_W-1:0]   green,
    output logic        [hsl2rgb_pkg::CH_W-1:0]   blue
);
    import hsl2rgb_pkg::*;

    localparam int DEPTH = 7;
    localparam int SC_W  = N_W + CS_W;
    localparam logic [N_W-1:0] N_MAX = N_W'(HUE_SECTOR) << (2 * SL_FRAC_BITS + 1);

    function automatic logic [CH_W-1:0] to_channel(input logic [N_W-1:0] n);
        logic [SC_W-1:0] scaled;
        logic [SC_W-1:0] q;
        scaled = SC_W'(n) * SC_W'(CH_SCALE);
        q      = scaled >> CH_SH;
        if (q > SC_W'((1 << CH_W) - 1))
            return '1;
        return q[CH_W-1:0];
    endfunction

    logic                      en;
    logic                      acc;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    logic signed [HUE_W-1:0]   skid_hue_reg;
    logic [SL_W-1:0]           skid_sat_reg;
    logic [SL_W-1:0]           skid_lit_reg;
    logic                      src_valid;
    logic signed [HUE_W-1:0]   src_hue;
    logic [SL_W-1:0]           src_sat;
    logic [SL_W-1:0]           src_lit;
    logic [DEPTH-1:0]          vld_reg;

    logic [SL_W-1:0]           sat_c;
    logic [SL_W-1:0]           lit_c;
    logic [SL_W:0]             twol;
    logic [SL_W:0]             lum_dev;
    logic [SL_W-1:0]           cdist;
    logic [2*SL_W-1:0]         cq_full;

    logic [CQ_W-1:0]           cq1_reg;
    logic [SL_W-1:0]           lit1_reg;
    logic [MB_W-1:0]           lone;
    logic [CQ_W-1:0]           cq2_reg, cq3_reg, cq4_reg;
    logic [MB_W-1:0]           mb2_reg, mb3_reg, mb4_reg;
    logic [MB_W-1:0]           hi2_reg, hi3_reg, hi4_reg;

    hue_res_t                  hue_res;
    logic [N_W-1:0]            xp5_reg, mn5_reg, a5_reg;
    sector_t                   sector5_reg;
    logic [N_W-1:0]            x6;
    logic [N_W-1:0]            r6_next, g6_next, b6_next;
    logic [N_W-1:0]            r6_reg, g6_reg, b6_reg;
    logic [CH_W-1:0]           red_reg, green_reg, blue_reg;

    assign en        = !(vld_reg[DEPTH-1] && rgb_stall);
    assign hsl_stall = skid_valid_reg;
    assign acc       = hsl_valid && !skid_valid_reg;

    assign src_valid = skid_valid_reg || hsl_valid;
    assign src_hue   = skid_valid_reg ? skid_hue_reg : hue;
    assign src_sat   = skid_valid_reg ? skid_sat_reg : saturation;
    assign src_lit   = skid_valid_reg ? skid_lit_reg : lightness;

    always_comb
    begin
        if (en)
            skid_valid_next = 1'b0;
        else if (acc)
            skid_valid_next = 1'b1;
        else
            skid_valid_next = skid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], src_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !en)
        begin
            skid_hue_reg <= hue;
            skid_sat_reg <= saturation;
            skid_lit_reg <= lightness;
        end
    end

    hsl2rgb_hue u_hue (
        .clk (clk),
        .en  (en),
        .hue (src_hue),
        .res (hue_res)
    );

    // stage 1: clamp, chroma = (1 - |2L - 1|) * S
    assign sat_c   = (src_sat > SL_W'(SL_ONE)) ? SL_W'(SL_ONE) : src_sat;
    assign lit_c   = (src_lit > SL_W'(SL_ONE)) ? SL_W'(SL_ONE) : src_lit;
    assign twol    = {lit_c, 1'b0};
    assign lum_dev = (twol >= (SL_W+1)'(SL_ONE)) ? twol - (SL_W+1)'(SL_ONE)
                                                 : (SL_W+1)'(SL_ONE) - twol;
    assign cdist   = SL_W'((SL_W+1)'(SL_ONE) - lum_dev);
    assign cq_full = {{SL_W{1'b0}}, cdist} * {{SL_W{1'b0}}, sat_c};

    // stage 2: 2L*ONE -/+ chroma
    assign lone = {lit1_reg, {(SL_FRAC_BITS+1){1'b0}}};

    // stage 6: place chroma and secondary by sector
    assign x6 = mn5_reg + xp5_reg;

    always_comb
    begin
        case (sector5_reg)
            SECTOR_R_Y:
            begin
                r6_next = a5_reg;  g6_next = x6;      b6_next = mn5_reg;
            end
            SECTOR_Y_G:
            begin
                r6_next = x6;      g6_next = a5_reg;  b6_next = mn5_reg;
            end
            SECTOR_G_C:
            begin
                r6_next = mn5_reg; g6_next = a5_reg;  b6_next = x6;
            end
            SECTOR_C_B:
            begin
                r6_next = mn5_reg; g6_next = x6;      b6_next = a5_reg;
            end
            SECTOR_B_M:
            begin
                r6_next = x6;      g6_next = mn5_reg; b6_next = a5_reg;
            end
            default:
            begin
                r6_next = a5_reg;  g6_next = mn5_reg; b6_next = x6;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cq1_reg     <= cq_full[CQ_W-1:0];
            lit1_reg    <= lit_c;
            cq2_reg     <= cq1_reg;
            mb2_reg     <= lone - MB_W'(cq1_reg);
            hi2_reg     <= lone + MB_W'(cq1_reg);
            cq3_reg     <= cq2_reg;
            mb3_reg     <= mb2_reg;
            hi3_reg     <= hi2_reg;
            cq4_reg     <= cq3_reg;
            mb4_reg     <= mb3_reg;
            hi4_reg     <= hi3_reg;
            xp5_reg     <= (N_W'(cq4_reg) * N_W'(hue_res.t)) << 1;
            mn5_reg     <= N_W'(mb4_reg) * N_W'(HUE_SECTOR);
            a5_reg      <= N_W'(hi4_reg) * N_W'(HUE_SECTOR);
            sector5_reg <= hue_res.sector;
            r6_reg      <= r6_next;
            g6_reg      <= g6_next;
            b6_reg      <= b6_next;
            red_reg     <= to_channel(r6_reg);
            green_reg   <= to_channel(g6_reg);
            blue_reg    <= to_channel(b6_reg);
        end
    end

    assign rgb_valid = vld_reg[DEPTH-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    `HSL_ASSERT(a_sector_range, clk, rst_n, vld_reg[3] |-> hue_res.sector <= SECTOR_M_R, "hue sector out of range")
    `HSL_ASSERT(a_t_range, clk, rst_n, vld_reg[3] |-> hue_res.t <= SEC_W'(HUE_SECTOR), "sector distance above sector width")
    `HSL_ASSERT(a_skid_hold, clk, rst_n, skid_valid_reg && !en |=> skid_valid_reg && $stable(skid_hue_reg), "skid item lost while stalled")
    `HSL_ASSERT(a_skid_drain, clk, rst_n, skid_valid_reg && en |=> !skid_valid_reg, "skid item not drained")
    `HSL_ASSERT_NEVER(a_sum_bound, clk, rst_n, vld_reg[5] && (r6_reg > N_MAX || g6_reg > N_MAX || b6_reg > N_MAX), "channel sum above full scale")

endmodule

### dv/hsl_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives directed corner colors and then random HSL items through the
// converter with bursty input and patterned output stalls. Every accepted
// item is converted by an integer model of the conversion, and the RGB
// results are compared channel by channel, in order.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    localparam int RANDOM_ITEMS   = 1900;
    localparam int DRAIN_EVERY    = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        logic signed [HUE_W-1:0] hue;
        logic [SL_W-1:0]         sat;
        logic [SL_W-1:0]         light;
        bit                      wait_drain;
    } hsl_item_t;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_item_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    hsl_valid  = 1'b0;
    logic                    hsl_stall;
    logic signed [HUE_W-1:0] hue        = '0;
    logic [SL_W-1:0]         saturation = '0;
    logic [SL_W-1:0]         lightness  = '0;
    logic                    rgb_valid;
    logic                    rgb_stall  = 1'b0;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;

    hsl_item_t pending_colors[$];
    rgb_item_t expected_rgb[$];

    int error_count  = 0;
    int result_count = 0;
    int idle_cycles  = 0;
    bit in_taken     = 1'b0;

    int burst_left = 0;
    int gap_left   = 0;

    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_phase     = 0;

    hsl_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsl_valid  (hsl_valid),
        .hsl_stall  (hsl_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] scale_channel(input longint unsigned num,
                                                      input longint unsigned den);
        longint unsigned q;
        q = (num * 255) / den;
        return (q > 255) ? 8'd255 : q[CH_W-1:0];
    endfunction

    function automatic rgb_item_t hsl_to_rgb(input hsl_item_t c);
        int                wrapped;
        int                sector_idx;
        sector_t           sector;
        longint unsigned   s, l, twol, lum_dev, cq, rem, t, sec, den, cn, xn, mn;
        longint unsigned   r, g, b;
        rgb_item_t         res;
        wrapped = int'(c.hue) % HUE_TURN;
        if (wrapped < 0)
            wrapped += HUE_TURN;
        s       = (c.sat > SL_ONE) ? SL_ONE : c.sat;
        l       = (c.light > SL_ONE) ? SL_ONE : c.light;
        twol    = 2 * l;
        lum_dev = (twol >= SL_ONE) ? twol - SL_ONE : SL_ONE - twol;
        cq      = (SL_ONE - lum_dev) * s;
        sector_idx = wrapped / HUE_SECTOR;
        sector     = sector_t'(sector_idx);
        sec  = HUE_SECTOR;
        rem  = wrapped - sector_idx * HUE_SECTOR;
        t    = sector_idx[0] ? sec - rem : rem;
        den  = 2 * SL_ONE * SL_ONE * sec;
        cn   = cq * sec * 2;
        xn   = cq * t * 2;
        mn   = l * SL_ONE * sec * 2 - cq * sec;
        r = 0;
        g = 0;
        b = 0;
        case (sector)
            SECTOR_R_Y: begin r = cn; g = xn; end
            SECTOR_Y_G: begin r = xn; g = cn; end
            SECTOR_G_C: begin g = cn; b = xn; end
            SECTOR_C_B: begin g = xn; b = cn; end
            SECTOR_B_M: begin r = xn; b = cn; end
            default:    begin r = cn; b = xn; end
        endcase
        res.red   = scale_channel(r + mn, den);
        res.green = scale_channel(g + mn, den);
        res.blue  = scale_channel(b + mn, den);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, result_count, msg);
        error_count++;
    endtask

    function automatic void queue_color(input int h, input int s, input int l,
                                        input bit drain);
        hsl_item_t c;
        c.hue        = h[HUE_W-1:0];
        c.sat        = s[SL_W-1:0];
        c.light      = l[SL_W-1:0];
        c.wait_drain = drain;
        pending_colors.push_back(c);
    endfunction

    function automatic int random_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, SL_ONE);
        else if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0: return 0;
                1: return 1;
                2: return SL_ONE / 2;
                3: return SL_ONE - 1;
                default: return SL_ONE;
            endcase
        end
        return $urandom_range(0, (1 << SL_W) - 1);
    endfunction

    function automatic int random_hue();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, HUE_TURN - 1);
        else if (pick < 85)
            return $urandom_range(0, (1 << HUE_W) - 1);
        return $urandom_range(0, SECTORS) * HUE_SECTOR + $urandom_range(0, 2) - 1;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        hsl_item_t c;
        if (rst_n && (!hsl_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                hsl_valid <= 1'b0;
            end
            else if (pending_colors.size() == 0 ||
                     (pending_colors[0].wait_drain && expected_rgb.size() != 0))
            begin
                hsl_valid <= 1'b0;
            end
            else
            begin
                c = pending_colors.pop_front();
                hue        <= c.hue;
                saturation <= c.sat;
                lightness  <= c.light;
                hsl_valid  <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 64);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall pattern changes mode every so often
    always @(negedge clk)
    begin
        bit stall_now;
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 300);
            stall_phase     = 0;
        end
        stall_mode_left--;
        stall_phase++;
        case (stall_mode)
            0: stall_now = 1'b0;
            1: stall_now = ($urandom_range(0, 3) == 0);
            2: stall_now = ($urandom_range(0, 3) != 0);
            default: stall_now = ((stall_phase % 5) < 3);
        endcase
        rgb_stall <= stall_now;
    end

    always @(posedge clk)
    begin
        hsl_item_t c;
        rgb_item_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (expected_rgb.size() == 0)
                    report_mismatch($sformatf("unexpected item rgb=%0d,%0d,%0d",
                                              red, green, blue));
                else
                begin
                    want = expected_rgb.pop_front();
                    if (red !== want.red)
                        report_mismatch($sformatf("red got %0d expected %0d",
                                                  red, want.red));
                    if (green !== want.green)
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  green, want.green));
                    if (blue !== want.blue)
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  blue, want.blue));
                end
                result_count++;
            end
            if (hsl_valid && !hsl_stall)
            begin
                c.hue        = hue;
                c.sat        = saturation;
                c.light      = lightness;
                c.wait_drain = 1'b0;
                expected_rgb.push_back(hsl_to_rgb(c));
                in_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (hsl_valid && !hsl_stall) || (rgb_valid && !rgb_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[hsl_to_rgb_converter] ERROR");
            $finish;
        end
    end

    initial
    begin
        // primaries, secondaries and mid-sector hues at full saturation, half lightness
        queue_color(0,                       SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(HUE_SECTOR,              SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(2 * HUE_SECTOR,          SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(3 * HUE_SECTOR,          SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(4 * HUE_SECTOR,          SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(5 * HUE_SECTOR,          SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(HUE_SECTOR / 2,          SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(3 * HUE_SECTOR / 2,      SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(HUE_TURN - 1,            SL_ONE,     SL_ONE / 2, 1'b0);
        // hue wrap: full turn, negative, extremes
        queue_color(HUE_TURN,                SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(-1,                      SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(-HUE_SECTOR,             SL_ONE / 2, SL_ONE / 3, 1'b0);
        queue_color(-32768,                  SL_ONE,     SL_ONE / 2, 1'b0);
        queue_color(32767,                   SL_ONE,     SL_ONE / 2, 1'b0);
        // gray, black, white, near black and near white
        queue_color(1000,                    0,          SL_ONE / 2, 1'b0);
        queue_color(1000,                    SL_ONE,     0,          1'b0);
        queue_color(1000,                    SL_ONE,     SL_ONE,     1'b0);
        queue_color(2500,                    1,          1,          1'b0);
        queue_color(2500,                    SL_ONE - 1, SL_ONE - 1, 1'b0);
        // out of range saturation and lightness clamp to one; last item in range
        queue_color(700,                     SL_ONE + 1, SL_ONE / 2, 1'b0);
        queue_color(700,                     8191,       SL_ONE / 4, 1'b0);
        queue_color(4000,                    SL_ONE / 2, SL_ONE + 1, 1'b0);
        queue_color(4000,                    8191,       8191,       1'b0);
        queue_color(5000,                    3 * SL_ONE / 4, 3 * SL_ONE / 4, 1'b0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            queue_color(random_hue(), random_unit(), random_unit(), (i % DRAIN_EVERY) == 0);

        repeat (2) @(posedge clk);
        #1 rst_n = 1'b1;

        while (pending_colors.size() != 0 || hsl_valid)
            @(posedge clk);
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[hsl_to_rgb_converter] OK");
        else
            $display("[hsl_to_rgb_converter] ERROR");
        $finish;
    end

endmodule
